// File: sv/timer_drift_ratio_estimator_assert.svh
// ------------------------------------------------------------------------
// timer drift ratio estimator assertion macros
// shared property forms used by the estimator's top module
// ------------------------------------------------------------------------
`ifndef TIMER_DRIFT_RATIO_ESTIMATOR_ASSERT_SVH
`define TIMER_DRIFT_RATIO_ESTIMATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TDRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tdre assertion failed");

// next-cycle implication, disabled in reset
`define TDRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tdre assertion failed");

`endif

// File: sv/tdre_pkg.sv
// ------------------------------------------------------------------------
// tdre_pkg
// constants, status codes and unit request types of the ratio estimator
// ------------------------------------------------------------------------
`default_nettype none

package tdre_pkg;

    localparam int TIMER_WIDTH_DEF = 32;
    localparam int WIDE_W          = 64;
    localparam int MPLIER_W        = 32;

    localparam logic [31:0] SHORT_PERIOD_US = 32'd2000000;
    localparam int          LIMIT_SHIFT     = 39;
    localparam int          DIFF_SHIFT      = 6;
    localparam int          EPOCH_SHIFT     = 9;
    localparam int          EXTRA_FRAC      = 7;
    localparam logic [63:0] SMOOTH_DIV      = 64'd10;
    localparam int          SCALE_SHIFT     = 32;

    // register reset values
    localparam logic [31:0] NOMINAL_RST = 32'd1024000000;
    localparam logic [31:0] MIN_RST     = 32'd1023897600;
    localparam logic [31:0] MAX_RST     = 32'd1024102400;
    localparam logic [15:0] MIN_SM_RST  = 16'd20;
    localparam logic [15:0] MAX_SM_RST  = 16'd100;

    // configuration register indexes
    localparam logic [2:0] REG_PERIOD  = 3'd0;
    localparam logic [2:0] REG_NOMINAL = 3'd1;
    localparam logic [2:0] REG_MIN     = 3'd2;
    localparam logic [2:0] REG_MAX     = 3'd3;
    localparam logic [2:0] REG_MIN_SM  = 3'd4;
    localparam logic [2:0] REG_MAX_SM  = 3'd5;

    // actions
    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_SKIP    = 2'd1;
    localparam logic [1:0] ACT_CONVERT = 2'd2;
    localparam logic [1:0] ACT_REINIT  = 2'd3;

    // sample status codes
    localparam logic [2:0] ST_OTHER    = 3'd0;
    localparam logic [2:0] ST_FIRST    = 3'd1;
    localparam logic [2:0] ST_ZERODIFF = 3'd2;
    localparam logic [2:0] ST_TOOBIG   = 3'd3;
    localparam logic [2:0] ST_WINDOW   = 3'd4;
    localparam logic [2:0] ST_ACCEPT   = 3'd5;
    localparam logic [2:0] ST_SMOOTHED = 3'd6;
    localparam logic [2:0] ST_NOPERIOD = 3'd7;

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] dividend;
        logic [WIDE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                start;
        logic [WIDE_W-1:0]   mcand;
        logic [MPLIER_W-1:0] mplier;
    } t_mul_req;

endpackage

`default_nettype wire

// File: sv/tdre_div.sv
// ------------------------------------------------------------------------
// tdre_div
// bit-serial restoring divider, one quotient bit per cycle
// ------------------------------------------------------------------------
`default_nettype none

module tdre_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire tdre_pkg::t_div_req      i_req,
    output logic                         o_done,
    output logic [tdre_pkg::WIDE_W-1:0]  o_quotient
);

    localparam int W   = tdre_pkg::WIDE_W;
    localparam int CW  = $clog2(W + 1);

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dsr;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    w_shift;
    logic [W:0]    w_diff;

    // trial subtract of the shifted partial remainder
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};

    // iteration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_diff[W]) begin
                    r_rem <= w_diff[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: sv/tdre_mul.sv
// ------------------------------------------------------------------------
// tdre_mul
// bit-serial shift-add multiplier, product kept modulo 2^64
// ------------------------------------------------------------------------
`default_nettype none

module tdre_mul (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire tdre_pkg::t_mul_req      i_req,
    output logic                         o_done,
    output logic [tdre_pkg::WIDE_W-1:0]  o_product
);

    localparam int W  = tdre_pkg::WIDE_W;
    localparam int MW = tdre_pkg::MPLIER_W;
    localparam int CW = $clog2(MW + 1);

    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_mcand;
    logic [MW-1:0] r_mplier;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    // one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_acc    <= '0;
                r_mcand  <= i_req.mcand;
                r_mplier <= i_req.mplier;
                r_cnt    <= CW'(MW);
                r_busy   <= 1'b1;
            end else if (r_busy) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[MW-1:1]};
                r_cnt    <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

// File: sv/timer_drift_ratio_estimator.sv
// serial units: none for skip, reinit, first sample and early rejects
// serial units: conversion uses one 64-step division
// serial units: add sample uses up to five 64-step divisions and two 32-step
//   multiplications on the shared serial units (short period case)
// throughput: one transaction at a time, next accepted once the result is registered
// reset: synchronous active low, registers to defaults, ratio to nominal value
// ------------------------------------------------------------------------
// timer_drift_ratio_estimator
// estimates microseconds per timer tick using serial divide and multiply
// ------------------------------------------------------------------------
`default_nettype none

`include "timer_drift_ratio_estimator_assert.svh"

module timer_drift_ratio_estimator #(
    parameter int TIMER_WIDTH = tdre_pkg::TIMER_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_action,
    input  wire  [31:0] i_timer_now,
    input  wire  [63:0] i_epoch_length,
    input  wire  [31:0] i_micros,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_sample_status,
    output logic [31:0] o_ratio,
    output logic [31:0] o_ticks,
    output logic [63:0] o_ticks_ext
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_DIV1, S_DIVI, S_MULI, S_DIVS, S_WIN,
        S_DIVA, S_MULA, S_DIVB, S_DONE
    } t_state;

    t_state r_state;

    logic [31:0] r_period, r_nominal, r_min, r_max;
    logic [15:0] r_min_sm, r_max_sm;

    logic                   r_have_prev;
    logic                   r_theoretical;
    logic [31:0]            r_ratio;
    logic [TIMER_WIDTH-1:0] r_prev_tick;
    logic [63:0]            r_prev_epoch;
    logic [15:0]            r_smooth;

    logic [63:0] r_divisor;
    logic [63:0] r_sample;
    logic [31:0] r_ip1;
    logic [15:0] r_a;
    logic [2:0]  r_status;
    logic [63:0] r_ext;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [31:0] r_out_ratio;
    logic [63:0] r_out_ext;

    tdre_pkg::t_div_req r_div_req;
    tdre_pkg::t_mul_req r_mul_req;
    logic        w_div_done, w_mul_done;
    logic [63:0] w_quo, w_prod;

    logic                   w_accept;
    logic [TIMER_WIDTH-1:0] w_now;
    logic [TIMER_WIDTH-1:0] w_diff;
    logic [63:0]            w_divisor;
    logic [63:0]            w_old_ext;
    logic [15:0]            w_q16;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_now     = i_timer_now[TIMER_WIDTH-1:0];
    assign w_diff    = w_now - r_prev_tick;
    assign w_old_ext = {25'b0, r_ratio, 7'b0};
    assign w_q16     = w_quo[15:0];

    // corrected tick difference
    assign w_divisor = (64'(w_diff) << tdre_pkg::DIFF_SHIFT)
                       - (i_epoch_length >> tdre_pkg::EPOCH_SHIFT)
                       + (r_prev_epoch >> tdre_pkg::EPOCH_SHIFT);

    tdre_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    tdre_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (r_mul_req),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    // sequencer, configuration and estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_period        <= '0;
            r_nominal       <= tdre_pkg::NOMINAL_RST;
            r_min           <= tdre_pkg::MIN_RST;
            r_max           <= tdre_pkg::MAX_RST;
            r_min_sm        <= tdre_pkg::MIN_SM_RST;
            r_max_sm        <= tdre_pkg::MAX_SM_RST;
            r_have_prev     <= 1'b0;
            r_theoretical   <= 1'b1;
            r_ratio         <= tdre_pkg::NOMINAL_RST;
            r_prev_tick     <= '0;
            r_prev_epoch    <= '0;
            r_smooth        <= tdre_pkg::MIN_SM_RST;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
            r_mul_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            r_mul_req.start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tdre_pkg::REG_PERIOD:  r_period  <= i_cfg_data;
                    tdre_pkg::REG_NOMINAL: r_nominal <= i_cfg_data;
                    tdre_pkg::REG_MIN:     r_min     <= i_cfg_data;
                    tdre_pkg::REG_MAX:     r_max     <= i_cfg_data;
                    tdre_pkg::REG_MIN_SM:  r_min_sm  <= i_cfg_data[15:0];
                    tdre_pkg::REG_MAX_SM:  r_max_sm  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_status <= tdre_pkg::ST_OTHER;
                        r_ext    <= '0;
                        r_state  <= S_DONE;
                        unique case (i_action)
                            tdre_pkg::ACT_ADD: begin
                                r_have_prev  <= 1'b1;
                                r_prev_tick  <= w_now;
                                r_prev_epoch <= i_epoch_length;
                                r_divisor    <= w_divisor;
                                if (!r_have_prev) begin
                                    r_status <= tdre_pkg::ST_FIRST;
                                end else if (w_diff == '0) begin
                                    r_status <= tdre_pkg::ST_ZERODIFF;
                                end else begin
                                    r_state <= S_CHK;
                                end
                            end
                            tdre_pkg::ACT_SKIP: begin
                                r_have_prev <= 1'b0;
                            end
                            tdre_pkg::ACT_CONVERT: begin
                                if (r_ratio == '0) begin
                                    r_ext <= '1;
                                end else begin
                                    r_div_req.start    <= 1'b1;
                                    r_div_req.dividend <= {i_micros, 32'b0};
                                    r_div_req.divisor  <= {32'b0, r_ratio};
                                    r_state            <= S_DIVB;
                                end
                            end
                            tdre_pkg::ACT_REINIT: begin
                                r_have_prev   <= 1'b0;
                                r_theoretical <= 1'b1;
                                r_ratio       <= r_nominal;
                                r_prev_tick   <= '0;
                                r_prev_epoch  <= '0;
                                r_smooth      <= r_min_sm;
                                r_period      <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_divisor == '0) begin
                        r_status <= tdre_pkg::ST_TOOBIG;
                        r_state  <= S_DONE;
                    end else if (r_period == '0) begin
                        r_status <= tdre_pkg::ST_NOPERIOD;
                        r_state  <= S_DONE;
                    end else begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= {r_period, 32'b0};
                        r_div_req.divisor  <= r_divisor;
                        r_state            <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (w_div_done) begin
                        r_sample <= w_quo << tdre_pkg::DIFF_SHIFT;
                        if (r_period < tdre_pkg::SHORT_PERIOD_US) begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= {32'b0,
                                tdre_pkg::SHORT_PERIOD_US + r_period - 32'd1};
                            r_div_req.divisor  <= {32'b0, r_period};
                            r_state            <= S_DIVI;
                        end else begin
                            r_state <= S_WIN;
                        end
                    end
                end
                S_DIVI: begin
                    if (w_div_done) begin
                        r_ip1              <= w_quo[31:0] + 32'd2;
                        r_mul_req.start    <= 1'b1;
                        r_mul_req.mcand    <= w_old_ext;
                        r_mul_req.mplier   <= w_quo[31:0] + 32'd1;
                        r_state            <= S_MULI;
                    end
                end
                S_MULI: begin
                    if (w_mul_done) begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= r_sample + w_prod + {33'b0, r_ip1[31:1]};
                        r_div_req.divisor  <= {32'b0, r_ip1};
                        r_state            <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    if (w_div_done) begin
                        r_sample <= w_quo;
                        r_state  <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_state <= S_DONE;
                    if (r_sample[63:tdre_pkg::LIMIT_SHIFT] != '0) begin
                        r_status <= tdre_pkg::ST_TOOBIG;
                    end else if (r_sample >= {25'b0, r_min, 7'b0}
                                 && r_sample <= {25'b0, r_max, 7'b0}) begin
                        if (r_theoretical) begin
                            r_theoretical <= 1'b0;
                            r_status      <= tdre_pkg::ST_ACCEPT;
                            r_ratio       <= r_sample[38:7];
                        end else begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= {48'b0, r_smooth};
                            r_div_req.divisor  <= tdre_pkg::SMOOTH_DIV;
                            r_state            <= S_DIVA;
                        end
                    end else begin
                        r_status <= tdre_pkg::ST_WINDOW;
                    end
                end
                S_DIVA: begin
                    if (w_div_done) begin
                        r_mul_req.start <= 1'b1;
                        r_mul_req.mcand <= w_old_ext;
                        if (w_q16 < 16'd2) begin
                            r_a              <= 16'd2;
                            r_mul_req.mplier <= 32'd1;
                        end else begin
                            r_a              <= w_q16;
                            r_mul_req.mplier <= {16'b0, w_q16 - 16'd1};
                        end
                        r_state <= S_MULA;
                    end
                end
                S_MULA: begin
                    if (w_mul_done) begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= r_sample + w_prod;
                        r_div_req.divisor  <= {48'b0, r_a};
                        r_status           <= tdre_pkg::ST_SMOOTHED;
                        r_state            <= S_DIVB;
                    end
                end
                S_DIVB: begin
                    // final division: smoothed sample or tick conversion
                    if (w_div_done) begin
                        if (r_status == tdre_pkg::ST_SMOOTHED) begin
                            r_ratio <= w_quo[38:7];
                            if (r_smooth >= r_max_sm) begin
                                r_smooth <= r_max_sm;
                            end else begin
                                r_smooth <= r_smooth + 16'd1;
                            end
                        end else begin
                            r_ext <= w_quo;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_ratio  <= r_ratio;
                        r_out_ext    <= r_ext;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_status = r_out_status;
    assign o_ratio         = r_out_ratio;
    assign o_ticks         = r_out_ext[38:7];
    assign o_ticks_ext     = r_out_ext;

    // a transaction is only taken while the sequencer is idle
    `TDRE_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    // divider results only arrive while a division is awaited
    `TDRE_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, w_div_done,
        r_state == S_DIV1 || r_state == S_DIVI || r_state == S_DIVS
        || r_state == S_DIVA || r_state == S_DIVB)
    // multiplier results only arrive while a product is awaited
    `TDRE_ASSERT_IMP(a_mul_owner, i_clk, i_rst_n, w_mul_done,
        r_state == S_MULI || r_state == S_MULA)
    // skip drops the stored previous epoch
    `TDRE_ASSERT_NXT(a_skip_clears, i_clk, i_rst_n,
        w_accept && i_action == tdre_pkg::ACT_SKIP, !r_have_prev)

endmodule

`default_nettype wire

// File: tb/sv/timer_drift_ratio_estimator_checker.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// timer_drift_ratio_estimator_checker
// watches the register port and both channels of the estimator, keeps its
// own copy of the ratio state, predicts each result and compares it
// ------------------------------------------------------------------------
module timer_drift_ratio_estimator_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [1:0]  i_action,
    input  wire  [31:0] i_timer_now,
    input  wire  [63:0] i_epoch_length,
    input  wire  [31:0] i_micros,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [2:0]  i_sample_status,
    input  wire  [31:0] i_ratio,
    input  wire  [31:0] i_ticks,
    input  wire  [63:0] i_ticks_ext,
    output int          o_fail_count
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ratio;
        logic [31:0] ticks;
        logic [63:0] ticks_ext;
    } t_estimate;

    t_estimate estimates_due[$];

    // register mirror
    logic [31:0] period_us, nominal, win_lo, win_hi;
    logic [15:0] smooth_floor, smooth_ceil;

    // estimator state mirror
    logic        have_prev, theoretical;
    logic [31:0] ratio_est, prev_tick;
    logic [63:0] prev_epoch;
    logic [15:0] smooth_cnt;

    initial o_fail_count = 0;

    task automatic restart_estimate();
        have_prev   = 1'b0;
        theoretical = 1'b1;
        ratio_est   = nominal;
        prev_tick   = '0;
        prev_epoch  = '0;
        smooth_cnt  = smooth_floor;
    endtask

    // status of one sample, updates the state mirror
    function automatic logic [2:0] take_sample(logic [31:0] now,
                                               logic [63:0] epoch);
        logic [31:0] diff;
        logic [63:0] old_ext, dvs, smp, wt, avg;
        logic [2:0]  st;
        if (!have_prev) begin
            have_prev  = 1'b1;
            prev_tick  = now;
            prev_epoch = epoch;
            return tdre_pkg::ST_FIRST;
        end
        diff    = now - prev_tick;
        old_ext = {25'd0, ratio_est, 7'd0};
        if (diff == 0) begin
            st = tdre_pkg::ST_ZERODIFF;
        end else begin
            dvs = ({32'd0, diff} << tdre_pkg::DIFF_SHIFT)
                  - (epoch >> tdre_pkg::EPOCH_SHIFT)
                  + (prev_epoch >> tdre_pkg::EPOCH_SHIFT);
            if (dvs == 0) begin
                st = tdre_pkg::ST_TOOBIG;
            end else if (period_us == 0) begin
                st = tdre_pkg::ST_NOPERIOD;
            end else begin
                smp = ({period_us, 32'd0} / dvs) << tdre_pkg::DIFF_SHIFT;
                // short period: pull toward the old ratio
                if (period_us < tdre_pkg::SHORT_PERIOD_US) begin
                    wt  = ({32'd0, tdre_pkg::SHORT_PERIOD_US} + {32'd0, period_us}
                           - 64'd1) / {32'd0, period_us} + 64'd1;
                    smp = (smp + wt * old_ext + (wt + 64'd1) / 64'd2) / (wt + 64'd1);
                end
                if (smp >= (64'd1 << tdre_pkg::LIMIT_SHIFT)) begin
                    st = tdre_pkg::ST_TOOBIG;
                end else if (smp >= {25'd0, win_lo, 7'd0}
                             && smp <= {25'd0, win_hi, 7'd0}) begin
                    if (theoretical) begin
                        theoretical = 1'b0;
                        st = tdre_pkg::ST_ACCEPT;
                    end else begin
                        avg = {48'd0, smooth_cnt} / tdre_pkg::SMOOTH_DIV;
                        if (avg < 2) avg = 64'd2;
                        smp = (smp + old_ext * (avg - 64'd1)) / avg;
                        if (smooth_cnt >= smooth_ceil) smooth_cnt = smooth_ceil;
                        else smooth_cnt = smooth_cnt + 16'd1;
                        st = tdre_pkg::ST_SMOOTHED;
                    end
                    ratio_est = smp[38:7];
                end else begin
                    st = tdre_pkg::ST_WINDOW;
                end
            end
        end
        prev_tick  = now;
        prev_epoch = epoch;
        return st;
    endfunction

    // register writes, reset and accepted transactions
    always @(posedge i_clk) begin
        t_estimate   due;
        logic [63:0] ext;
        if (!i_rst_n) begin
            period_us    = '0;
            nominal      = tdre_pkg::NOMINAL_RST;
            win_lo       = tdre_pkg::MIN_RST;
            win_hi       = tdre_pkg::MAX_RST;
            smooth_floor = tdre_pkg::MIN_SM_RST;
            smooth_ceil  = tdre_pkg::MAX_SM_RST;
            restart_estimate();
            estimates_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tdre_pkg::REG_PERIOD:  period_us    = i_cfg_data;
                    tdre_pkg::REG_NOMINAL: nominal      = i_cfg_data;
                    tdre_pkg::REG_MIN:     win_lo       = i_cfg_data;
                    tdre_pkg::REG_MAX:     win_hi       = i_cfg_data;
                    tdre_pkg::REG_MIN_SM:  smooth_floor = i_cfg_data[15:0];
                    tdre_pkg::REG_MAX_SM:  smooth_ceil  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                ext        = '0;
                due.status = tdre_pkg::ST_OTHER;
                case (i_action)
                    tdre_pkg::ACT_ADD:
                        due.status = take_sample(i_timer_now, i_epoch_length);
                    tdre_pkg::ACT_SKIP: have_prev = 1'b0;
                    tdre_pkg::ACT_CONVERT: begin
                        if (ratio_est == 0) ext = '1;
                        else ext = {i_micros, 32'd0} / {32'd0, ratio_est};
                    end
                    default: begin
                        restart_estimate();
                        period_us = '0;
                    end
                endcase
                due.ratio     = ratio_est;
                due.ticks     = ext[38:7];
                due.ticks_ext = ext;
                estimates_due.push_back(due);
            end
        end
    end

    // result comparison
    always @(posedge i_clk) begin
        t_estimate due;
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (estimates_due.size() == 0) begin
                o_fail_count++;
                if (o_fail_count <= 10)
                    $display("%0t: result with nothing expected: status %0d ratio %0d",
                             $realtime, i_sample_status, i_ratio);
            end else begin
                due = estimates_due.pop_front();
                if (due.status !== i_sample_status || due.ratio !== i_ratio ||
                    due.ticks !== i_ticks || due.ticks_ext !== i_ticks_ext) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: mismatch, expected status %0d ratio %0d ticks %0d ext %0d",
                                 $realtime, due.status, due.ratio, due.ticks, due.ticks_ext);
                        $display("%0t:           actual status %0d ratio %0d ticks %0d ext %0d",
                                 $realtime, i_sample_status, i_ratio, i_ticks, i_ticks_ext);
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/timer_drift_ratio_estimator_test.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// timer_drift_ratio_estimator_test
// drives directed and random synchronization epochs through the estimator
// under several register settings and idling patterns; a checker beside
// the block predicts and compares every result
// ------------------------------------------------------------------------
module timer_drift_ratio_estimator_test;

    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int PHASE_ITEMS  = 140;
    localparam int PHASES       = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_action = tdre_pkg::ACT_ADD;
    logic [31:0] i_timer_now = '0;
    logic [63:0] i_epoch_length = '0;
    logic [31:0] i_micros = '0;
    logic        i_out_stall = 1'b0;
    wire         o_in_stall, o_out_valid;
    wire  [2:0]  o_sample_status;
    wire  [31:0] o_ratio, o_ticks;
    wire  [63:0] o_ticks_ext;
    int          fail_count;

    int          sent_count = 0, done_count = 0, quiet_cycles = 0;
    int          idle_mode = 0;
    bit          hold_req = 1'b0;
    logic [31:0] last_tick = '0, period_now = '0;
    logic [31:0] nominal_now = tdre_pkg::NOMINAL_RST;
    logic [63:0] last_epoch = '0;

    timer_drift_ratio_estimator DUT (.*);

    timer_drift_ratio_estimator_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_action, .i_timer_now,
        .i_epoch_length, .i_micros, .i_out_valid(o_out_valid), .i_out_stall,
        .i_sample_status(o_sample_status), .i_ratio(o_ratio), .i_ticks(o_ticks),
        .i_ticks_ext(o_ticks_ext), .o_fail_count(fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // transaction counts and watchdog
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) done_count++;
        if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timer_drift_ratio_estimator_test failed");
            $finish;
        end
    end

    // receiver: random stalls, with one long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                case (idle_mode)
                    2: i_out_stall <= ($urandom_range(0, 99) < 48);
                    3: i_out_stall <= ($urandom_range(0, 99) < 6);
                    default: i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic send(logic [1:0] act, logic [31:0] now, logic [63:0] epoch,
                        logic [31:0] us);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 48 : (idle_mode == 3) ? 6 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_timer_now    <= now;
        i_epoch_length <= epoch;
        i_micros       <= us;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
        if (act == tdre_pkg::ACT_ADD) begin
            last_tick  = now;
            last_epoch = epoch;
        end
        if (act == tdre_pkg::ACT_REINIT) period_now = '0;
    endtask

    // add whose corrected divisor gives the nominal ratio off by ppm_off
    task automatic send_epoch(int ppm_off);
        logic [63:0] target, step, fine;
        longint      skew;
        target = ({32'd0, period_now} << 31) / {32'd0, nominal_now};
        skew   = longint'(target / 64'd1000000) * ppm_off;
        target = target + 64'(skew);
        step   = (target >> 6) + 64'd1;
        fine   = (step << 6) - target;
        send(tdre_pkg::ACT_ADD, last_tick + step[31:0],
             {(last_epoch[63:9] + fine[54:0]), 9'($urandom)},
             $urandom);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (done_count != sent_count) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] per, logic [31:0] nom, logic [31:0] lo,
                              logic [31:0] hi, logic [15:0] sm_lo, logic [15:0] sm_hi);
        logic [31:0] vals [6];
        vals = '{per, nom, lo, hi, {16'd0, sm_lo}, {16'd0, sm_hi}};
        for (int r = 0; r < 6; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        period_now  = per;
        nominal_now = nom;
    endtask

    task automatic restore_period();
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tdre_pkg::REG_PERIOD;
        i_cfg_data  <= period_now;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] saved_period;
        int          pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: zero period gives no-period status
        send(tdre_pkg::ACT_CONVERT, '0, '0, '0);
        send(tdre_pkg::ACT_ADD, '0, '0, '0);
        send(tdre_pkg::ACT_ADD, 32'd1000, '0, '1);
        wait_drained();

        write_regs(32'd10000000, tdre_pkg::NOMINAL_RST, tdre_pkg::MIN_RST,
                   tdre_pkg::MAX_RST, 16'd20, 16'd100);
        // directed: extremes and special cases
        send(tdre_pkg::ACT_SKIP, '0, '0, '0);
        send(tdre_pkg::ACT_CONVERT, '0, '0, '1);
        send(tdre_pkg::ACT_ADD, '1, '1, '0);
        send(tdre_pkg::ACT_ADD, last_tick, last_epoch, '0);
        send(tdre_pkg::ACT_ADD, last_tick + 32'd1, last_epoch + 64'd32768, '0);
        send(tdre_pkg::ACT_ADD, last_tick + 32'd1, last_epoch, '0);
        send_epoch(0);
        send_epoch(20);
        send_epoch(-30);
        send_epoch(5000);
        send_epoch(-5000);
        send_epoch(0);
        send(tdre_pkg::ACT_CONVERT, '1, '1, '1);
        send(tdre_pkg::ACT_SKIP, '1, '1, '1);
        send_epoch(0);
        send_epoch(10);
        send(tdre_pkg::ACT_REINIT, '0, '0, '0);
        send_epoch(0);
        send_epoch(0);
        saved_period = 32'd10000000;
        period_now   = saved_period;
        restore_period();

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: write_regs(32'd10000000, tdre_pkg::NOMINAL_RST, tdre_pkg::MIN_RST,
                              tdre_pkg::MAX_RST, 16'd20, 16'd100);
                1: write_regs(32'd1000000, tdre_pkg::NOMINAL_RST, 32'd1013760000,
                              32'd1034240000, 16'd0, 16'd65535);
                2: write_regs('1, '1, 32'd1, '1, 16'd65535, 16'd0);
                3: write_regs(32'd1, 32'd1, 32'd1, 32'd1000, 16'd5, 16'd40);
                default: write_regs(32'd3000000, 32'h12345678, 32'h121EB2D8, 32'h124A3E18,
                                    16'd30, 16'd80);
            endcase
            idle_mode = ph % 4;
            if (ph == 1) hold_req = 1'b1;
            // phases in idle mode 0 start with a stretch without idling
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == 20 && idle_mode == 0) idle_mode = 3;
                pick = $urandom_range(0, 99);
                if (pick < 66) send_epoch($signed($urandom_range(0, 600)) - 300);
                else if (pick < 76)
                    send(tdre_pkg::ACT_CONVERT, $urandom, {$urandom, $urandom}, $urandom);
                else if (pick < 80)
                    send(tdre_pkg::ACT_SKIP, $urandom, {$urandom, $urandom}, $urandom);
                else if (pick < 90)
                    send(tdre_pkg::ACT_ADD, $urandom, {$urandom, $urandom}, $urandom);
                else if (pick < 95)
                    send(tdre_pkg::ACT_ADD, last_tick, {$urandom, $urandom}, $urandom);
                else if (pick < 98)
                    send(tdre_pkg::ACT_ADD, last_tick + 32'($urandom_range(1, 4)),
                         last_epoch, $urandom);
                else begin
                    saved_period = period_now;
                    send(tdre_pkg::ACT_REINIT, $urandom, {$urandom, $urandom}, $urandom);
                    period_now = saved_period;
                    restore_period();
                end
            end
        end

        wait_drained();
        repeat (500) @(posedge i_clk);
        if (fail_count == 0)
            $display("timer_drift_ratio_estimator_test passed");
        else
            $display("timer_drift_ratio_estimator_test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/tdre_pkg.sv
sv/tdre_div.sv
sv/tdre_mul.sv
sv/timer_drift_ratio_estimator.sv
tb/sv/timer_drift_ratio_estimator_checker.sv
tb/sv/timer_drift_ratio_estimator_test.sv
